FILE: design/mhpq_pkg.sv
// ----------------------------------------------------------------------------
// mhpq_pkg: shared types and constants for the max-heap priority queue
// Sizes, status and command codes, register map and the per-cell control word.
// ----------------------------------------------------------------------------
package mhpq_pkg;

    // storage size and field widths
    localparam int DEPTH   = 64;
    localparam int KEY_W   = 32;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int CAP_W   = 7;
    localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    // stream word widths, padded to whole bytes
    localparam int S_TDATA_W = ((KEY_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((KEY_W + CNT_W + 7) / 8) * 8;
    localparam int M_TUSER_W = 2;

    // apb register map
    localparam int APB_DW  = 32;
    localparam int PADDR_W = 3;
    localparam int REGIX_W = PADDR_W - 2;
    localparam logic [REGIX_W-1:0] REG_CAPACITY = '0;
    localparam logic [CAP_W-1:0]   CAP_RESET    = CAP_W'(64);

    // command codes on the input tuser
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef logic signed [KEY_W-1:0] t_key;
    typedef logic [CNT_W-1:0]        t_count;

    // broadcast to every cell in the row
    typedef struct packed {
        logic insert;
        logic remove;
        t_key key;
    } t_cell_ctrl;

endpackage

FILE: design/mhpq_cell.sv
// ----------------------------------------------------------------------------
// mhpq_cell: one slot of the sorted key row
// Holds one key; on insert it keeps its key, takes the new key or takes its
// upper neighbor's key; on remove it takes its lower neighbor's key.
// ----------------------------------------------------------------------------
module mhpq_cell (
    input  logic                i_clk,
    input  mhpq_pkg::t_cell_ctrl i_ctrl,
    input  logic                i_occupied,
    input  logic                i_prev_ge,
    input  mhpq_pkg::t_key      i_prev_value,
    input  mhpq_pkg::t_key      i_next_value,
    output mhpq_pkg::t_key      o_value,
    output logic                o_ge
);

    mhpq_pkg::t_key r_value;
    mhpq_pkg::t_key n_value;

    // slot stays above the new key when it holds a key no smaller
    assign o_ge    = i_occupied && (r_value >= i_ctrl.key);
    assign o_value = r_value;

    // next key for this slot
    always_comb begin
        n_value = r_value;
        if (i_ctrl.insert && !o_ge) begin
            n_value = i_prev_ge ? i_ctrl.key : i_prev_value;
        end else if (i_ctrl.remove) begin
            n_value = i_next_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

FILE: design/max_heap_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// max_heap_priority_queue_unit: bounded priority queue of signed keys
// Insert and remove-max commands on a row of cells kept in descending order.
//
//  channel   dir   handshake              payload
//  s_axis    in    tvalid/tready          tdata: key_value; tuser: command
//  m_axis    out   tvalid/tready          tdata: max_value, entry_count;
//                                         tuser: status
//  apb       in    psel/penable/pready    capacity_limit at address 0
//
// One word per cycle while the result is not stalled: every cell updates in the
// accept cycle, the result shows in the next cycle and a new word may follow at once.
// The result register frees the input side: input is taken whenever the
// result register is empty or its word is taken in the same cycle.
// Reset clears the count, the capacity to its default and the result valid.
// A stalled result holds its word and stalls the input side.
// ----------------------------------------------------------------------------
module max_heap_priority_queue_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [mhpq_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // [31:0] key_value
    input  logic                              s_axis_tuser,  // [0] command
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [mhpq_pkg::M_TDATA_W-1:0]    m_axis_tdata,  // max_value, entry_count
    output logic [mhpq_pkg::M_TUSER_W-1:0]    m_axis_tuser,  // [1:0] status
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mhpq_pkg::PADDR_W-1:0]      paddr,
    input  logic [mhpq_pkg::APB_DW-1:0]       pwdata,
    output logic [mhpq_pkg::APB_DW-1:0]       prdata,
    output logic                              pready
);

    localparam int DEPTH = mhpq_pkg::DEPTH;
    localparam int CNT_W = mhpq_pkg::CNT_W;
    localparam int CMP_W = mhpq_pkg::CMP_W;

    logic [mhpq_pkg::CAP_W-1:0] r_cap;
    mhpq_pkg::t_count           r_count;
    mhpq_pkg::t_count           n_count;
    logic                       r_out_valid;
    mhpq_pkg::t_status          r_out_status;
    mhpq_pkg::t_status          n_status;
    mhpq_pkg::t_key             r_out_max;
    mhpq_pkg::t_key             n_max;

    logic                       w_accept;
    logic                       w_is_remove;
    logic [CMP_W-1:0]           w_cap_eff;
    logic                       w_full;
    logic                       w_empty;
    logic                       w_cfg_write;
    logic                       w_cfg_hit;
    mhpq_pkg::t_cell_ctrl       w_ctrl;
    mhpq_pkg::t_key             w_value [DEPTH];
    logic                       w_ge    [DEPTH];

    // apb register access
    assign pready      = 1'b1;
    assign w_cfg_hit   = (paddr[mhpq_pkg::PADDR_W-1:2] == mhpq_pkg::REG_CAPACITY);
    assign w_cfg_write = psel && penable && pwrite && pready;
    assign prdata      = w_cfg_hit ? mhpq_pkg::APB_DW'(r_cap) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= mhpq_pkg::CAP_RESET;
        end else if (w_cfg_write && w_cfg_hit) begin
            r_cap <= pwdata[mhpq_pkg::CAP_W-1:0];
        end
    end

    // input handshake and command decode
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_is_remove   = (s_axis_tuser == mhpq_pkg::CMD_REMOVE);

    // capacity saturates at the storage size
    assign w_cap_eff = (CMP_W'(r_cap) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(r_cap);
    assign w_full    = (CMP_W'(r_count) >= w_cap_eff);
    assign w_empty   = (r_count == '0);

    assign w_ctrl.insert = w_accept && !w_is_remove && !w_full;
    assign w_ctrl.remove = w_accept && w_is_remove && !w_empty;
    assign w_ctrl.key    = s_axis_tdata[mhpq_pkg::KEY_W-1:0];

    // row of cells, largest key in the first cell
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic           w_prev_ge;
        mhpq_pkg::t_key w_prev_value;
        mhpq_pkg::t_key w_next_value;

        if (g == 0) begin : g_head
            assign w_prev_ge    = 1'b1;
            assign w_prev_value = '0;
        end else begin : g_body
            assign w_prev_ge    = w_ge[g-1];
            assign w_prev_value = w_value[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_next_value = '0;
        end else begin : g_link
            assign w_next_value = w_value[g+1];
        end

        mhpq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_occupied   (CNT_W'(g) < r_count),
            .i_prev_ge    (w_prev_ge),
            .i_prev_value (w_prev_value),
            .i_next_value (w_next_value),
            .o_value      (w_value[g]),
            .o_ge         (w_ge[g])
        );
    end

    // result of the accepted word
    always_comb begin
        n_count  = r_count;
        n_status = mhpq_pkg::ST_OK;
        n_max    = '0;
        if (w_is_remove) begin
            if (w_empty) begin
                n_status = mhpq_pkg::ST_EMPTY;
            end else begin
                n_max   = w_value[0];
                n_count = r_count - CNT_W'(1);
            end
        end else begin
            if (w_full) begin
                n_status = mhpq_pkg::ST_FULL;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end
    end

    // count and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_status <= n_status;
            r_out_max    <= n_max;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = mhpq_pkg::M_TDATA_W'({r_count, r_out_max});
    assign m_axis_tuser  = r_out_status;

endmodule

FILE: design/mhpq_checker.sv
// ----------------------------------------------------------------------------
// mhpq_checker: port-level checks for the priority queue
// Watches the stream ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
module mhpq_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [mhpq_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic [mhpq_pkg::M_TUSER_W-1:0] m_axis_tuser
);

    localparam int KEY_W = mhpq_pkg::KEY_W;
    localparam int CNT_W = mhpq_pkg::CNT_W;

    // input side open right after reset
    a_ready_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) && i_rst_n |-> s_axis_tready)
        else $error("input not ready after reset");

    // every accepted word shows a result next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("no result after accepted word");

    // stalled result holds
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // refused remove leaves an empty queue and no key
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == mhpq_pkg::ST_EMPTY) |->
            (m_axis_tdata[KEY_W+CNT_W-1:0] == '0))
        else $error("empty status with data");

endmodule

bind max_heap_priority_queue_unit mhpq_checker u_mhpq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for max_heap_priority_queue_unit
// Streams insert and remove-max words under random gaps and back-pressure,
// mirrors the heap in a behavioral model and checks every result word field
// by field. Capacity is changed over apb between phases, including zero,
// values above the store size and values below the current entry count.
// ----------------------------------------------------------------------------
module tb;
    import mhpq_pkg::*;

    typedef struct {
        logic cmd;
        t_key key;
    } t_heap_cmd;

    typedef struct {
        t_status status;
        t_key    max_value;
        t_count  count;
    } t_heap_result;

    localparam logic [REGIX_W-1:0] REG_SPARE     = REGIX_W'(1);
    localparam logic [PADDR_W-1:0] ADDR_CAPACITY = {REG_CAPACITY, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_SPARE    = {REG_SPARE, 2'b00};
    localparam int                 LONG_HOLD     = 64;
    localparam int                 MAX_PRINTS    = 50;

    // dut ports
    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;          // [31:0] key_value
    logic                 s_axis_tuser  = CMD_INSERT;  // [0] command
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;                // [31:0] max_value, [38:32] entry_count
    logic [M_TUSER_W-1:0] m_axis_tuser;                // [1:0] status
    logic                 psel          = 1'b0;
    logic                 penable       = 1'b0;
    logic                 pwrite        = 1'b0;
    logic [PADDR_W-1:0]   paddr         = '0;
    logic [APB_DW-1:0]    pwdata        = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    max_heap_priority_queue_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // heap mirror and its capacity register
    t_key             heap_keys [DEPTH];
    int unsigned      heap_size = 0;
    logic [CAP_W-1:0] cap_reg   = CAP_RESET;

    // bookkeeping
    t_heap_cmd    pending_cmds [$];
    t_heap_result expected_results [$];
    int           n_queued   = 0;
    int           n_accepted = 0;
    int           n_checked  = 0;
    int           n_errors   = 0;
    int           n_full     = 0;
    int           n_empty    = 0;
    int           peak_count = 0;
    bit           cmd_taken  = 1'b0;

    // idling controls
    bit           tx_idle_en   = 1'b1;
    bit           rx_idle_en   = 1'b1;
    int           tx_gap       = 0;
    int           rx_gap       = 0;
    int           rx_hold_seq  = 0;
    int           rx_hold_done = 0;
    int           rx_hold_left = 0;

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (n_errors < MAX_PRINTS)
            $display("MISMATCH t=%0t result %0d %s: got %0h expected %0h",
                     $time, n_checked, what, got, want);
        n_errors++;
    endtask

    // one heap step: insert with sift-up, or remove-max with sift-down
    function automatic t_heap_result heap_predict(logic cmd, t_key key);
        t_heap_result r;
        int unsigned  limit;
        int unsigned  pos;
        int unsigned  par;
        int unsigned  kid;
        t_key         tmp;
        r.status    = ST_OK;
        r.max_value = '0;
        limit = (cap_reg > DEPTH) ? DEPTH : cap_reg;
        if (cmd == CMD_INSERT) begin
            if (heap_size >= limit) begin
                r.status = ST_FULL;
            end else begin
                pos = heap_size;
                heap_keys[pos] = key;
                while (pos > 0) begin
                    par = (pos - 1) / 2;
                    if (!(heap_keys[par] < key))
                        break;
                    heap_keys[pos] = heap_keys[par];
                    heap_keys[par] = key;
                    pos = par;
                end
                heap_size++;
            end
        end else if (heap_size == 0) begin
            r.status = ST_EMPTY;
        end else begin
            r.max_value = heap_keys[0];
            heap_size--;
            heap_keys[0] = heap_keys[heap_size];
            pos = 0;
            while (2 * pos + 1 < heap_size) begin
                kid = 2 * pos + 1;
                // right child only when present and strictly larger
                if (kid + 1 < heap_size && heap_keys[kid + 1] > heap_keys[kid])
                    kid++;
                if (!(heap_keys[pos] < heap_keys[kid]))
                    break;
                tmp = heap_keys[pos];
                heap_keys[pos] = heap_keys[kid];
                heap_keys[kid] = tmp;
                pos = kid;
            end
        end
        r.count = t_count'(heap_size);
        return r;
    endfunction

    // command driver: holds a word until taken, random gaps between words
    always @(negedge i_clk) begin : drive_cmds
        t_heap_cmd c;
        logic      nxt_valid;
        nxt_valid = s_axis_tvalid && !cmd_taken;
        if (!nxt_valid) begin
            if (tx_gap > 0) begin
                tx_gap--;
            end else if (pending_cmds.size() > 0) begin
                c = pending_cmds.pop_front();
                s_axis_tdata <= c.key;
                s_axis_tuser <= c.cmd;
                nxt_valid = 1'b1;
                if (tx_idle_en && $urandom_range(0, 4) == 0)
                    tx_gap = $urandom_range(1, 6);
            end
        end
        s_axis_tvalid <= nxt_valid;
    end

    // result ready: long hold on request, otherwise random stall bursts
    always @(negedge i_clk) begin : drive_ready
        if (rx_hold_seq != rx_hold_done) begin
            rx_hold_done = rx_hold_seq;
            rx_hold_left = LONG_HOLD;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_axis_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (rx_idle_en && $urandom_range(0, 4) == 0)
                rx_gap = $urandom_range(1, 6);
        end
    end

    // monitor: register writes, accepted commands and result words
    always @(posedge i_clk) begin : monitor
        t_heap_result want;
        cmd_taken = 1'b0;
        if (i_rst_n) begin
            if (psel && penable && pwrite && pready && paddr[PADDR_W-1:2] == REG_CAPACITY)
                cap_reg = pwdata[CAP_W-1:0];
            if (s_axis_tvalid && s_axis_tready) begin
                cmd_taken = 1'b1;
                n_accepted++;
                expected_results.push_back(heap_predict(s_axis_tuser, s_axis_tdata));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected word", m_axis_tdata, '0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_axis_tuser !== want.status)
                        report_mismatch("status", m_axis_tuser, want.status);
                    if (m_axis_tdata[KEY_W-1:0] !== want.max_value)
                        report_mismatch("max_value", m_axis_tdata[KEY_W-1:0], want.max_value);
                    if (m_axis_tdata[KEY_W +: CNT_W] !== want.count)
                        report_mismatch("entry_count", m_axis_tdata[KEY_W +: CNT_W],
                                        want.count);
                    if (want.status == ST_FULL)
                        n_full++;
                    if (want.status == ST_EMPTY)
                        n_empty++;
                    if (want.count > peak_count)
                        peak_count = want.count;
                end
                n_checked++;
            end
        end
    end

    task automatic queue_cmd(logic cmd, t_key key);
        t_heap_cmd c;
        c.cmd = cmd;
        c.key = key;
        pending_cmds.push_back(c);
        n_queued++;
    endtask

    // wait until every queued word is taken and every result has come back
    task automatic wait_drained();
        do @(negedge i_clk);
        while (n_accepted != n_queued || expected_results.size() != 0);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic apb_write(logic [PADDR_W-1:0] addr, logic [APB_DW-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk);
        while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // idle write of the capacity with junk upper bits, then read back
    task automatic set_capacity(logic [CAP_W-1:0] value);
        logic [APB_DW-1:0] data;
        wait_drained();
        data = $urandom();
        data[CAP_W-1:0] = value;
        apb_write(ADDR_CAPACITY, data);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        paddr   <= ADDR_CAPACITY;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk);
        while (!pready);
        if (prdata !== APB_DW'(cap_reg))
            report_mismatch("capacity readback", prdata, cap_reg);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // keys near the extremes, small values with many duplicates, or anything
    function automatic t_key rand_key();
        case ($urandom_range(0, 5))
            0:       return t_key'(32'h7FFF_FFFF) - t_key'($urandom_range(0, 3));
            1:       return t_key'(32'h8000_0000) + t_key'($urandom_range(0, 3));
            2:       return t_key'($urandom_range(0, 15)) - t_key'(8);
            default: return t_key'($urandom());
        endcase
    endfunction

    // mostly-insert stretch that fills the heap, then a mostly-remove drain
    task automatic heap_round(int unsigned fill_len, int unsigned drain_len);
        repeat (fill_len)
            queue_cmd(($urandom_range(0, 99) < 92) ? CMD_INSERT : CMD_REMOVE, rand_key());
        repeat (drain_len)
            queue_cmd(($urandom_range(0, 99) < 10) ? CMD_INSERT : CMD_REMOVE, rand_key());
    endtask

    initial begin : stimulus
        logic [CAP_W-1:0] cap_pick;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // remove on empty, key extremes, duplicates, alternating bits, full drain
        queue_cmd(CMD_REMOVE, '0);
        queue_cmd(CMD_INSERT, t_key'(32'h7FFF_FFFF));
        queue_cmd(CMD_INSERT, t_key'(32'h8000_0000));
        queue_cmd(CMD_INSERT, t_key'(32'h0000_0000));
        queue_cmd(CMD_INSERT, t_key'(32'hFFFF_FFFF));
        queue_cmd(CMD_INSERT, t_key'(32'h7FFF_FFFF));
        queue_cmd(CMD_INSERT, t_key'(32'hAAAA_AAAA));
        queue_cmd(CMD_INSERT, t_key'(32'h5555_5555));
        repeat (7) queue_cmd(CMD_REMOVE, t_key'(32'hFFFF_FFFF));

        // capacity of one
        set_capacity(CAP_W'(1));
        queue_cmd(CMD_INSERT, t_key'(1234));
        queue_cmd(CMD_INSERT, t_key'(5));
        queue_cmd(CMD_REMOVE, '0);

        // capacity of zero refuses every insert
        set_capacity(CAP_W'(0));
        queue_cmd(CMD_INSERT, t_key'(-77));
        queue_cmd(CMD_REMOVE, '0);

        // write to the unused register index must change nothing
        wait_drained();
        apb_write(ADDR_SPARE, '1);
        queue_cmd(CMD_INSERT, t_key'(99));

        // capacity lowered below the current count
        set_capacity(CAP_W'(DEPTH));
        repeat (4) queue_cmd(CMD_INSERT, rand_key());
        set_capacity(CAP_W'(2));
        queue_cmd(CMD_INSERT, rand_key());
        queue_cmd(CMD_REMOVE, '0);
        queue_cmd(CMD_REMOVE, '0);
        queue_cmd(CMD_INSERT, rand_key());
        queue_cmd(CMD_REMOVE, '0);
        queue_cmd(CMD_INSERT, rand_key());
        queue_cmd(CMD_INSERT, rand_key());

        // capacity above the store size saturates
        set_capacity(7'd127);
        heap_round(DEPTH + 10, DEPTH + 10);

        // tiny capacity, no idling on either side
        set_capacity(CAP_W'(2));
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        heap_round(12, 12);

        // random capacity in range
        cap_pick = CAP_W'($urandom_range(1, DEPTH));
        set_capacity(cap_pick);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        heap_round(cap_pick + 10, cap_pick + 10);

        // long result stall while the sender keeps offering words
        set_capacity(CAP_W'(DEPTH));
        rx_hold_seq++;
        heap_round(DEPTH + 10, DEPTH + 10);

        // small random capacity
        cap_pick = CAP_W'($urandom_range(1, 16));
        set_capacity(cap_pick);
        heap_round(cap_pick + 10, cap_pick + 10);

        // last stretch without idling, capacity above the store size
        wait_drained();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        cap_pick = CAP_W'($urandom_range(DEPTH + 1, 127));
        set_capacity(cap_pick);
        heap_round(DEPTH + 10, DEPTH + 10);

        wait_drained();
        repeat (8) @(posedge i_clk);
        $display("run: %0d commands, %0d results checked, %0d refused inserts, %0d empty removes",
                 n_accepted, n_checked, n_full, n_empty);
        $display("heap peaked at %0d entries; capacities 0 to 127, one long result stall",
                 peak_count);
        if (n_errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("timeout: %0d results still outstanding", expected_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
